// File: hw/rtl/cone_avoid_drive_controller_macros.svh
// ----------------------------------------------------------------------------
// Cone avoid drive controller assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONE_AVOID_DRIVE_CONTROLLER_MACROS_SVH
`define CONE_AVOID_DRIVE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cad assertion failed");

// next-cycle implication
`define CAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cad assertion failed");

`endif

// File: hw/rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller package
// Codes, constants and shared types of the drive controller.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam logic [11:0]        DIST_RESET       = 12'd1280;
  localparam logic [3:0]         STOP_HOLD        = 4'd5;
  localparam logic [3:0]         STOP_END         = 4'd12;
  localparam logic signed [12:0] REVERSE_THROTTLE = -13'sd20;

  typedef enum logic [1:0] {
    ACT_CONE   = 2'd0,
    ACT_DECIDE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  localparam logic [1:0] SECT_LEFT   = 2'd0;
  localparam logic [1:0] SECT_FRONT  = 2'd1;
  localparam logic [1:0] SECT_RIGHT  = 2'd2;
  localparam logic [1:0] SECT_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    MODE_STOP    = 3'd0,
    MODE_REVERSE = 3'd1,
    MODE_LEFT    = 3'd2,
    MODE_RIGHT   = 3'd3,
    MODE_FWD2    = 3'd4,
    MODE_FWD3    = 3'd5,
    MODE_UNSET   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    FLAG_NONE   = 2'd0,
    FLAG_STOP   = 2'd1,
    FLAG_ADJUST = 2'd2,
    FLAG_UNSET  = 2'd3
  } flag_t;

  localparam logic [2:0] REG_BASE_SPEED     = 3'd0;
  localparam logic [2:0] REG_SPEED_STEP     = 3'd1;
  localparam logic [2:0] REG_TURN_GAIN      = 3'd2;
  localparam logic [2:0] REG_TRIM_GAIN      = 3'd3;
  localparam logic [2:0] REG_COLLISION_DIST = 3'd4;
  localparam logic [2:0] REG_NEAR_DIST      = 3'd5;
  localparam logic [2:0] REG_FAR_DIST       = 3'd6;
  localparam logic [2:0] REG_STEP_DIST      = 3'd7;

  typedef struct packed {
    logic [9:0]  base_speed;
    logic [7:0]  speed_step;
    logic [9:0]  turn_gain;
    logic [9:0]  trim_gain;
    logic [11:0] collision_dist;
    logic [11:0] near_dist;
    logic [11:0] far_dist;
    logic [11:0] step_dist;
  } cfg_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] front;
    logic [11:0] right;
  } dists_t;

  typedef struct packed {
    logic               stop_latched;
    logic               trim_on;
    logic [3:0]         stop_cnt;
    mode_t              mode;
    flag_t              flag;
    logic signed [12:0] throttle;
    logic signed [10:0] steer;
  } drive_t;

endpackage

// File: hw/rtl/cad_in_if.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller input channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface cad_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  sector;
  logic [11:0] cone_distance;

  modport source (output valid, action, sector, cone_distance, input ready);
  modport sink   (input valid, action, sector, cone_distance, output ready);
endinterface

// File: hw/rtl/cad_out_if.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller result channel
// Valid/ready channel carrying one drive command word.
// ----------------------------------------------------------------------------
interface cad_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] throttle;
  logic signed [10:0] steer;
  logic [2:0]         drive_mode;
  logic [1:0]         flag_code;

  modport source (output valid, throttle, steer, drive_mode, flag_code, input ready);
  modport sink   (input valid, throttle, steer, drive_mode, flag_code, output ready);
endinterface

// File: hw/rtl/cad_decide.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller decision logic
// Classifies sector distances and forms the next drive state and command.
// ----------------------------------------------------------------------------
module cad_decide (
  input  cad_pkg::cfg_t   cfg,
  input  cad_pkg::dists_t dists,
  input  cad_pkg::drive_t cur,
  output cad_pkg::drive_t nxt
);

  logic               collide;
  logic               right_room;
  logic [14:0]        front_w;
  logic [14:0]        near_w;
  logic [14:0]        band_w;
  logic [14:0]        hi1, hi2, hi3, hi4;
  logic signed [12:0] base_s;
  logic signed [12:0] thr_k1, thr_k2, thr_k3, thr_k4, thr_k5;
  logic signed [10:0] turn_s;
  logic signed [10:0] trim_s;
  logic [10:0]        step_w;

  assign collide    = (dists.front < cfg.collision_dist) || (dists.right < cfg.collision_dist)
                      || (dists.left < cfg.collision_dist);
  assign right_room = dists.right >= dists.left;

  assign front_w = {3'd0, dists.front};
  assign near_w  = {3'd0, cfg.near_dist};
  assign band_w  = {3'd0, cfg.step_dist};
  assign hi1     = near_w + band_w;
  assign hi2     = near_w + (band_w << 1);
  assign hi3     = near_w + (band_w << 1) + band_w;
  assign hi4     = near_w + (band_w << 2);

  assign step_w  = {3'd0, cfg.speed_step};
  assign base_s  = $signed({3'd0, cfg.base_speed});
  assign thr_k1  = base_s + $signed({2'd0, step_w});
  assign thr_k2  = base_s + $signed({2'd0, step_w << 1});
  assign thr_k3  = base_s + $signed({2'd0, (step_w << 1) + step_w});
  assign thr_k4  = base_s + $signed({2'd0, step_w << 2});
  assign thr_k5  = base_s + $signed({2'd0, (step_w << 2) + step_w});
  assign turn_s  = $signed({1'b0, cfg.turn_gain});
  assign trim_s  = $signed({1'b0, cfg.trim_gain});

  always_comb begin
    nxt = cur;
    if (collide) begin
      nxt.stop_latched = 1'b1;
      nxt.trim_on      = 1'b0;
      nxt.flag         = cad_pkg::FLAG_STOP;
    end else if (dists.front < cfg.near_dist) begin
      nxt.trim_on = 1'b0;
      nxt.mode    = right_room ? cad_pkg::MODE_RIGHT : cad_pkg::MODE_LEFT;
      nxt.flag    = cad_pkg::FLAG_NONE;
    end else if (dists.front < cfg.far_dist) begin
      nxt.mode    = cad_pkg::MODE_FWD2;
      nxt.flag    = cad_pkg::FLAG_ADJUST;
      nxt.trim_on = 1'b1;
    end else begin
      nxt.mode    = cad_pkg::MODE_FWD3;
      nxt.flag    = cad_pkg::FLAG_ADJUST;
      nxt.trim_on = 1'b1;
    end

    if (nxt.stop_latched) begin
      if (cur.stop_cnt < cad_pkg::STOP_HOLD) begin
        nxt.mode     = cad_pkg::MODE_STOP;
        nxt.throttle = '0;
        nxt.steer    = '0;
        nxt.stop_cnt = cur.stop_cnt + 4'd1;
      end else if (cur.stop_cnt < cad_pkg::STOP_END) begin
        nxt.mode     = cad_pkg::MODE_REVERSE;
        nxt.throttle = cad_pkg::REVERSE_THROTTLE;
        nxt.steer    = '0;
        nxt.stop_cnt = cur.stop_cnt + 4'd1;
      end else begin
        nxt.mode         = cad_pkg::MODE_REVERSE;
        nxt.stop_latched = 1'b0;
        nxt.stop_cnt     = 4'd1;
      end
    end else begin
      case (nxt.mode)
        cad_pkg::MODE_LEFT: begin
          nxt.throttle = base_s;
          nxt.steer    = turn_s;
        end
        cad_pkg::MODE_RIGHT: begin
          nxt.throttle = base_s;
          nxt.steer    = -turn_s;
        end
        cad_pkg::MODE_FWD3: begin
          nxt.throttle = thr_k5;
          nxt.steer    = '0;
        end
        cad_pkg::MODE_FWD2: begin
          nxt.steer = '0;
          if (front_w >= near_w && front_w < hi1) begin
            nxt.throttle = thr_k1;
          end else if (front_w >= hi1 && front_w < hi2) begin
            nxt.throttle = thr_k2;
          end else if (front_w >= hi2 && front_w < hi3) begin
            nxt.throttle = thr_k3;
          end else if (front_w >= hi3 && front_w < hi4) begin
            nxt.throttle = thr_k4;
          end
        end
        default: begin
          nxt.throttle = cur.throttle;
        end
      endcase
    end

    if (nxt.trim_on) begin
      nxt.steer = right_room ? -trim_s : trim_s;
    end
  end

endmodule

// File: hw/rtl/cone_avoid_drive_controller.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller
// Tracks nearest cone per sector and issues throttle/steer commands.
//
//   channel  | dir | handshake     | word
//   in_word  | in  | valid/ready   | action, sector, cone_distance
//   out_word | out | valid/ready   | throttle, steer, drive_mode, flag_code
//   cfg_*    | in  | write enable  | cfg_index, cfg_wdata
//
// One word per cycle while no decide word waits; a decide word is taken
// into the input register, then decision logic fills the result register.
// Only a decide word waits on a full result register; other words pass.
// Reset is synchronous: distances 1280, mode unset, flag unset, registers
// at their defaults.
// ----------------------------------------------------------------------------
`include "cone_avoid_drive_controller_macros.svh"

module cone_avoid_drive_controller (
  input  logic             clk,
  input  logic             rst_n,
  cad_in_if.sink           in_word,
  cad_out_if.source        out_word,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [11:0]      cfg_wdata
);

  cad_pkg::cfg_t   cfg_r;
  logic            in_valid_r;
  logic [1:0]      act_r;
  logic [1:0]      sect_r;
  logic [11:0]     cone_r;
  logic [11:0]     dist_r [3];
  cad_pkg::drive_t drive_r;
  cad_pkg::drive_t drive_nxt;
  cad_pkg::dists_t dists;
  logic            out_valid_r;
  logic signed [12:0] out_throttle_r;
  logic signed [10:0] out_steer_r;
  logic [2:0]      out_mode_r;
  logic [1:0]      out_flag_r;
  logic            is_decide;
  logic            out_free;
  logic            adv;

  assign is_decide = act_r == cad_pkg::ACT_DECIDE;
  assign out_free  = !out_valid_r || out_word.ready;
  assign adv       = in_valid_r && (!is_decide || out_free);
  assign in_word.ready = !in_valid_r || adv;

  assign dists = '{left: dist_r[0], front: dist_r[1], right: dist_r[2]};

  cad_decide u_decide (
    .cfg   (cfg_r),
    .dists (dists),
    .cur   (drive_r),
    .nxt   (drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed     <= 10'd256;
      cfg_r.speed_step     <= 8'd0;
      cfg_r.turn_gain      <= 10'd141;
      cfg_r.trim_gain      <= 10'd26;
      cfg_r.collision_dist <= 12'd26;
      cfg_r.near_dist      <= 12'd448;
      cfg_r.far_dist       <= 12'd806;
      cfg_r.step_dist      <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        cad_pkg::REG_BASE_SPEED:     cfg_r.base_speed     <= cfg_wdata[9:0];
        cad_pkg::REG_SPEED_STEP:     cfg_r.speed_step     <= cfg_wdata[7:0];
        cad_pkg::REG_TURN_GAIN:      cfg_r.turn_gain      <= cfg_wdata[9:0];
        cad_pkg::REG_TRIM_GAIN:      cfg_r.trim_gain      <= cfg_wdata[9:0];
        cad_pkg::REG_COLLISION_DIST: cfg_r.collision_dist <= cfg_wdata;
        cad_pkg::REG_NEAR_DIST:      cfg_r.near_dist      <= cfg_wdata;
        cad_pkg::REG_FAR_DIST:       cfg_r.far_dist       <= cfg_wdata;
        cad_pkg::REG_STEP_DIST:      cfg_r.step_dist      <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      in_valid_r <= in_word.valid;
    end
    if (in_word.valid && in_word.ready) begin
      act_r  <= in_word.action;
      sect_r <= in_word.sector;
      cone_r <= in_word.cone_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r[0]             <= cad_pkg::DIST_RESET;
      dist_r[1]             <= cad_pkg::DIST_RESET;
      dist_r[2]             <= cad_pkg::DIST_RESET;
      drive_r.stop_latched  <= 1'b0;
      drive_r.trim_on       <= 1'b0;
      drive_r.stop_cnt      <= 4'd0;
      drive_r.mode          <= cad_pkg::MODE_UNSET;
      drive_r.flag          <= cad_pkg::FLAG_UNSET;
      drive_r.throttle      <= '0;
      drive_r.steer         <= '0;
    end else if (adv) begin
      case (act_r)
        cad_pkg::ACT_CONE: begin
          if (sect_r != cad_pkg::SECT_UNUSED && cone_r < dist_r[sect_r]) begin
            dist_r[sect_r] <= cone_r;
          end
        end
        cad_pkg::ACT_DECIDE: begin
          drive_r <= drive_nxt;
        end
        cad_pkg::ACT_CLEAR: begin
          dist_r[0] <= cad_pkg::DIST_RESET;
          dist_r[1] <= cad_pkg::DIST_RESET;
          dist_r[2] <= cad_pkg::DIST_RESET;
        end
        default: drive_r <= drive_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && is_decide) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && is_decide) begin
      out_throttle_r <= drive_nxt.throttle;
      out_steer_r    <= drive_nxt.steer;
      out_mode_r     <= drive_nxt.mode;
      out_flag_r     <= drive_nxt.flag;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.throttle   = out_throttle_r;
  assign out_word.steer      = out_steer_r;
  assign out_word.drive_mode = out_mode_r;
  assign out_word.flag_code  = out_flag_r;

  `CAD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, drive_r.stop_cnt <= cad_pkg::STOP_END)
  `CAD_ASSERT_NOW(a_cnt_idle, clk, rst_n, !drive_r.stop_latched, drive_r.stop_cnt <= 4'd1)
  `CAD_ASSERT_NOW(a_dist_bound, clk, rst_n, 1'b1,
    dist_r[0] <= cad_pkg::DIST_RESET && dist_r[1] <= cad_pkg::DIST_RESET && dist_r[2] <= cad_pkg::DIST_RESET)
  `CAD_ASSERT_NEXT(a_decide_out, clk, rst_n, adv && is_decide, out_valid_r)
  `CAD_ASSERT_NOW(a_stop_zero, clk, rst_n, out_valid_r && out_mode_r == cad_pkg::MODE_STOP,
    out_throttle_r == 13'sd0 && out_steer_r == 11'sd0 || drive_r.trim_on)

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Cone avoid drive controller testbench
// Drives command words into the controller under random gaps and result
// stalls, mirrors the sector distances and the drive state in a local model,
// and checks every drive command word against the model in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam cad_pkg::cfg_t RESET_CFG = '{base_speed: 10'd256, speed_step: 8'd0,
                                          turn_gain: 10'd141, trim_gain: 10'd26,
                                          collision_dist: 12'd26, near_dist: 12'd448,
                                          far_dist: 12'd806, step_dist: 12'd256};

  typedef struct {
    logic signed [12:0] throttle;
    logic signed [10:0] steer;
    cad_pkg::mode_t     mode;
    cad_pkg::flag_t     flag;
  } drive_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_wdata;

  cad_in_if  in_word ();
  cad_out_if out_word ();

  cone_avoid_drive_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cad_pkg::cfg_t   model_cfg;
  cad_pkg::dists_t model_dists;
  cad_pkg::drive_t model_drive;
  drive_cmd_t      pending_cmds[$];

  int          errors;
  int          words_sent;
  bit          src_idle;
  bit          sink_idle;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void decide_drive();
    logic [11:0] l, f, r;
    logic        room_right;
    logic        hit;
    int          lo, hi;
    drive_cmd_t  cmd;
    l = model_dists.left;
    f = model_dists.front;
    r = model_dists.right;
    room_right = (r >= l);
    hit = 1'b0;
    if (f < model_cfg.collision_dist || r < model_cfg.collision_dist ||
        l < model_cfg.collision_dist) begin
      model_drive.stop_latched = 1'b1;
      model_drive.trim_on = 1'b0;
      model_drive.flag = cad_pkg::FLAG_STOP;
    end else if (f < model_cfg.near_dist) begin
      model_drive.trim_on = 1'b0;
      model_drive.mode = room_right ? cad_pkg::MODE_RIGHT : cad_pkg::MODE_LEFT;
      model_drive.flag = cad_pkg::FLAG_NONE;
    end else if (f < model_cfg.far_dist) begin
      model_drive.mode = cad_pkg::MODE_FWD2;
      model_drive.flag = cad_pkg::FLAG_ADJUST;
      model_drive.trim_on = 1'b1;
    end else begin
      model_drive.mode = cad_pkg::MODE_FWD3;
      model_drive.flag = cad_pkg::FLAG_ADJUST;
      model_drive.trim_on = 1'b1;
    end

    if (model_drive.stop_latched) begin
      if (model_drive.stop_cnt < cad_pkg::STOP_HOLD) begin
        model_drive.mode = cad_pkg::MODE_STOP;
        model_drive.throttle = '0;
        model_drive.steer = '0;
      end else begin
        model_drive.mode = cad_pkg::MODE_REVERSE;
        if (model_drive.stop_cnt < cad_pkg::STOP_END) begin
          model_drive.throttle = cad_pkg::REVERSE_THROTTLE;
          model_drive.steer = '0;
        end else begin
          model_drive.stop_cnt = '0;
          model_drive.stop_latched = 1'b0;
        end
      end
      model_drive.stop_cnt = model_drive.stop_cnt + 4'd1;
    end else begin
      case (model_drive.mode)
        cad_pkg::MODE_LEFT: begin
          model_drive.throttle = 13'(int'(model_cfg.base_speed));
          model_drive.steer = 11'(int'(model_cfg.turn_gain));
        end
        cad_pkg::MODE_RIGHT: begin
          model_drive.throttle = 13'(int'(model_cfg.base_speed));
          model_drive.steer = 11'(-int'(model_cfg.turn_gain));
        end
        cad_pkg::MODE_FWD3: begin
          model_drive.throttle =
            13'(int'(model_cfg.base_speed) + 5 * int'(model_cfg.speed_step));
          model_drive.steer = '0;
        end
        cad_pkg::MODE_FWD2: begin
          model_drive.steer = '0;
          for (int k = 1; k <= 4; k++) begin
            lo = int'(model_cfg.near_dist) + (k - 1) * int'(model_cfg.step_dist);
            hi = lo + int'(model_cfg.step_dist);
            if (!hit && int'(f) >= lo && int'(f) < hi) begin
              model_drive.throttle =
                13'(int'(model_cfg.base_speed) + k * int'(model_cfg.speed_step));
              hit = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (model_drive.trim_on)
      model_drive.steer = room_right ? 11'(-int'(model_cfg.trim_gain))
                                     : 11'(int'(model_cfg.trim_gain));

    cmd.throttle = model_drive.throttle;
    cmd.steer = model_drive.steer;
    cmd.mode = model_drive.mode;
    cmd.flag = model_drive.flag;
    pending_cmds.push_back(cmd);
  endfunction

  function automatic void track_word(logic [1:0] act, logic [1:0] sect, logic [11:0] cone_d);
    case (act)
      cad_pkg::ACT_CONE: begin
        if (sect == cad_pkg::SECT_LEFT && cone_d < model_dists.left)
          model_dists.left = cone_d;
        if (sect == cad_pkg::SECT_FRONT && cone_d < model_dists.front)
          model_dists.front = cone_d;
        if (sect == cad_pkg::SECT_RIGHT && cone_d < model_dists.right)
          model_dists.right = cone_d;
      end
      cad_pkg::ACT_DECIDE: decide_drive();
      cad_pkg::ACT_CLEAR: begin
        model_dists.left = cad_pkg::DIST_RESET;
        model_dists.front = cad_pkg::DIST_RESET;
        model_dists.right = cad_pkg::DIST_RESET;
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [1:0] sect,
                           input logic [11:0] cone_d);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.action <= act;
    in_word.sector <= sect;
    in_word.cone_distance <= cone_d;
    do @(posedge clk); while (!in_word.ready);
    track_word(act, sect, cone_d);
    if (act != ACT_UNUSED && !(act == cad_pkg::ACT_CONE && sect == cad_pkg::SECT_UNUSED))
      words_sent++;
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input cad_pkg::cfg_t c);
    logic [11:0] field [8];
    field[cad_pkg::REG_BASE_SPEED]     = {2'($urandom), c.base_speed};
    field[cad_pkg::REG_SPEED_STEP]     = {4'($urandom), c.speed_step};
    field[cad_pkg::REG_TURN_GAIN]      = {2'($urandom), c.turn_gain};
    field[cad_pkg::REG_TRIM_GAIN]      = {2'($urandom), c.trim_gain};
    field[cad_pkg::REG_COLLISION_DIST] = c.collision_dist;
    field[cad_pkg::REG_NEAR_DIST]      = c.near_dist;
    field[cad_pkg::REG_FAR_DIST]       = c.far_dist;
    field[cad_pkg::REG_STEP_DIST]      = c.step_dist;
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= field[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_cfg = c;
  endtask

  function automatic cad_pkg::cfg_t rand_cfg();
    cad_pkg::cfg_t c;
    c.base_speed     = 10'($urandom);
    c.speed_step     = 8'($urandom);
    c.turn_gain      = 10'($urandom);
    c.trim_gain      = 10'($urandom);
    c.collision_dist = 12'($urandom_range(0, 300));
    c.near_dist      = 12'($urandom);
    c.far_dist       = 12'($urandom);
    c.step_dist      = 12'($urandom_range(0, 1200));
    return c;
  endfunction

  function automatic logic [11:0] pick_dist();
    int d;
    case ($urandom_range(0, 11))
      0:       d = int'(model_cfg.collision_dist);
      1, 2:    d = int'(model_cfg.near_dist);
      3, 4, 5: d = int'(model_cfg.near_dist) +
                   int'($urandom_range(1, 4)) * int'(model_cfg.step_dist);
      6:       d = int'(model_cfg.far_dist);
      default: return 12'($urandom_range(0, 4095));
    endcase
    d = d + int'($urandom_range(0, 6)) - 3;
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    return 12'(d);
  endfunction

  task automatic send_episode();
    int unsigned n;
    if ($urandom_range(0, 7) == 0) begin
      send_word(2'($urandom), 2'($urandom), 12'($urandom));
      return;
    end
    if ($urandom_range(0, 1) == 1) send_word(cad_pkg::ACT_CLEAR, 2'($urandom), 12'($urandom));
    n = $urandom_range(0, 4);
    repeat (n) send_word(cad_pkg::ACT_CONE, 2'($urandom_range(0, 2)), pick_dist());
    send_word(cad_pkg::ACT_DECIDE, 2'($urandom), 12'($urandom));
  endtask

  task automatic run_traffic(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      send_episode();
    end
  endtask

  task automatic test_defaults_and_ignored();
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_LEFT, 12'd0);
    send_word(ACT_UNUSED, cad_pkg::SECT_FRONT, 12'hFFF);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_UNUSED, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_LEFT, 12'hFFF);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_UNUSED, 12'hFFF);
  endtask

  task automatic test_turns();
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd300);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_RIGHT, 12'd200);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_RIGHT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_LEFT, 12'd200);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_LEFT, 12'd0);
  endtask

  task automatic test_throttle_staircase();
    cad_pkg::cfg_t c;
    c = '{base_speed: 10'd100, speed_step: 8'd37, turn_gain: 10'd500, trim_gain: 10'd1023,
          collision_dist: 12'd40, near_dist: 12'd300, far_dist: 12'd2000,
          step_dist: 12'd200};
    load_config(c);
    send_word(cad_pkg::ACT_CLEAR, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd1900);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd1050);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd850);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd650);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_FRONT, 12'd450);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_FRONT, 12'd0);
  endtask

  task automatic test_collision_latch();
    send_word(cad_pkg::ACT_CONE, cad_pkg::SECT_LEFT, 12'd0);
    send_word(cad_pkg::ACT_DECIDE, cad_pkg::SECT_LEFT, 12'd0);
    send_word(cad_pkg::ACT_CLEAR, cad_pkg::SECT_LEFT, 12'd0);
  endtask

  task automatic test_config_sweep();
    cad_pkg::cfg_t c;
    c = '0;
    load_config(c);
    run_traffic(60);
    c = '{base_speed: 10'd1023, speed_step: 8'd255, turn_gain: 10'd1023,
          trim_gain: 10'd1023, collision_dist: 12'd4095, near_dist: 12'd4095,
          far_dist: 12'd4095, step_dist: 12'd4095};
    load_config(c);
    run_traffic(60);
    c.collision_dist = '0;
    c.near_dist = '0;
    c.far_dist = '0;
    load_config(c);
    run_traffic(60);
    c = rand_cfg();
    c.near_dist = 12'd100;
    c.far_dist = 12'd3000;
    c.step_dist = '0;
    load_config(c);
    run_traffic(60);
    repeat (2) begin
      load_config(rand_cfg());
      run_traffic(60);
    end
  endtask

  task automatic test_result_backpressure();
    drain();
    src_idle = 1'b0;
    stall_cycles = 300;
    repeat (40) begin
      send_word(cad_pkg::ACT_CONE, 2'($urandom_range(0, 2)), pick_dist());
      send_word(cad_pkg::ACT_DECIDE, 2'($urandom), 12'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    load_config(RESET_CFG);
    run_traffic(500);
    load_config(rand_cfg());
    run_traffic(450);
  endtask

  initial begin : result_sink
    int unsigned wait_left;
    logic        want;
    wait_left = 0;
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      want = out_word.ready;
      if (stall_cycles > 0) begin
        wait_left = stall_cycles;
        stall_cycles = 0;
        want = 1'b0;
      end else if (!out_word.ready) begin
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) want = 1'b1;
      end else if (out_word.valid) begin
        wait_left = sink_idle ? $urandom_range(0, 19) : 0;
        if (wait_left > 0) want = 1'b0;
      end
      if (want != out_word.ready) out_word.ready <= want;
    end
  end

  always @(posedge clk) begin : result_check
    drive_cmd_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d", $time,
                 out_word.throttle, out_word.steer, out_word.drive_mode, out_word.flag_code);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_word.throttle !== want.throttle) begin
          $display("%0t: throttle expected %0d actual %0d", $time, want.throttle,
                   out_word.throttle);
          errors++;
        end
        if (out_word.steer !== want.steer) begin
          $display("%0t: steer expected %0d actual %0d", $time, want.steer, out_word.steer);
          errors++;
        end
        if (out_word.drive_mode !== want.mode) begin
          $display("%0t: drive_mode expected %0d actual %0d", $time, want.mode,
                   out_word.drive_mode);
          errors++;
        end
        if (out_word.flag_code !== want.flag) begin
          $display("%0t: flag_code expected %0d actual %0d", $time, want.flag,
                   out_word.flag_code);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    errors = 0;
    words_sent = 0;
    stall_cycles = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    model_cfg = RESET_CFG;
    model_dists = '{left: cad_pkg::DIST_RESET, front: cad_pkg::DIST_RESET,
                    right: cad_pkg::DIST_RESET};
    model_drive = '{stop_latched: 1'b0, trim_on: 1'b0, stop_cnt: 4'd0,
                    mode: cad_pkg::MODE_UNSET, flag: cad_pkg::FLAG_UNSET,
                    throttle: 13'sd0, steer: 11'sd0};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cad_pkg::REG_BASE_SPEED;
    cfg_wdata <= '0;
    in_word.valid <= 1'b0;
    in_word.action <= cad_pkg::ACT_CONE;
    in_word.sector <= cad_pkg::SECT_LEFT;
    in_word.cone_distance <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_and_ignored();
    test_turns();
    test_throttle_staircase();
    test_collision_latch();
    test_config_sweep();
    test_result_backpressure();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: cone_avoid_drive_controller.f
+incdir+hw/rtl
hw/rtl/cad_pkg.sv
hw/rtl/cad_in_if.sv
hw/rtl/cad_out_if.sv
hw/rtl/cad_decide.sv
hw/rtl/cone_avoid_drive_controller.sv
tb/sv/tb_top.sv
